@@ sv/bgnc_pkg.sv @@
// Package for the binary grid neighbour count block.
// Shared widths, register indexes, sequencer state type and line store control.
// No dependencies.
`default_nettype none

package bgnc_pkg;

    // Configuration register widths and indexes
    localparam int CFG_ROWS_W = 11;
    localparam int CFG_COLS_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLS = 2'd1;

    // Reset values of the grid size registers
    localparam logic [CFG_ROWS_W-1:0] GRID_ROWS_RST = 11'd3;
    localparam logic [CFG_COLS_W-1:0] GRID_COLS_RST = 6'd3;

    // Grid limits
    localparam int MAX_ROWS     = 1024;
    localparam int MAX_COLS_DEF = 32;

    // Result field widths
    localparam int COUNT_W   = 4;
    localparam int OUT_ROW_W = 10;
    localparam int OUT_COL_W = 5;

    // Window sum runs over three columns, one per cycle
    localparam int           STEP_W    = 2;
    localparam logic [1:0]   STEP_LAST = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_OUTPUT,
        ST_UPDATE
    } seq_state_t;

    // Line store control from the sequencer
    typedef struct packed {
        logic wr_en;    // store the incoming bit in the current row
        logic wr_bit;
        logic advance;  // move rows up one, current row cleared
        logic clear;    // clear all three rows
    } line_ctrl_t;

endpackage

`default_nettype wire

@@ sv/bgnc_lines.sv @@
// Three row line stores (two rows up, one row up, current row) for the window.
// Depends on bgnc_pkg.
`default_nettype none

module bgnc_lines #(
    parameter int   MAX_COLS = bgnc_pkg::MAX_COLS_DEF,
    localparam int  COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire bgnc_pkg::line_ctrl_t  ctrl,
    input  wire logic [COL_W-1:0]      wr_col,
    input  wire logic [COL_W-1:0]      rd_col,
    output logic [2:0]                 rd_bits   // [2] two up, [1] one up, [0] current
);
    import bgnc_pkg::*;

    logic [MAX_COLS-1:0] two_reg, two_next;
    logic [MAX_COLS-1:0] one_reg, one_next;
    logic [MAX_COLS-1:0] cur_reg, cur_next;

    // Clear wins over row advance, advance over a bit write
    always_comb begin
        two_next = two_reg;
        one_next = one_reg;
        cur_next = cur_reg;
        if (ctrl.clear) begin
            two_next = '0;
            one_next = '0;
            cur_next = '0;
        end else if (ctrl.advance) begin
            two_next = one_reg;
            one_next = cur_reg;
            cur_next = '0;
        end else if (ctrl.wr_en) begin
            cur_next[wr_col] = ctrl.wr_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            two_reg <= '0;
            one_reg <= '0;
            cur_reg <= '0;
        end else begin
            two_reg <= two_next;
            one_reg <= one_next;
            cur_reg <= cur_next;
        end
    end

    // One column of the window
    assign rd_bits = {two_reg[rd_col], one_reg[rd_col], cur_reg[rd_col]};

endmodule

`default_nettype wire

@@ sv/bgnc_seq.sv @@
// Sequencer and shared window adder: position counters, result list walk,
// three-column accumulation and the result register. Depends on bgnc_pkg.
`default_nettype none

module bgnc_seq #(
    parameter int   MAX_COLS = bgnc_pkg::MAX_COLS_DEF,
    localparam int  COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                restart,
    input  wire logic [bgnc_pkg::CFG_ROWS_W-1:0]     last_row,
    input  wire logic [COL_W-1:0]                    last_col,
    // input beats
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic                                bomb,
    // line stores
    output bgnc_pkg::line_ctrl_t                     line_ctrl,
    output logic [COL_W-1:0]                         wr_col,
    output logic [COL_W-1:0]                         rd_col,
    input  wire logic [2:0]                          rd_bits,
    // result beats
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [bgnc_pkg::COUNT_W-1:0]             count,
    output logic [bgnc_pkg::OUT_ROW_W-1:0]           out_row,
    output logic [bgnc_pkg::OUT_COL_W-1:0]           out_col,
    output logic                                     run_last
);
    import bgnc_pkg::*;

    seq_state_t              state_reg, state_next;
    logic [CFG_ROWS_W-1:0]   in_row_reg, in_row_next;
    logic [COL_W-1:0]        in_col_reg, in_col_next;
    logic [COL_W-1:0]        tgt_col_reg, tgt_col_next;
    logic                    flush_reg, flush_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [COUNT_W-1:0]      acc_reg, acc_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [OUT_ROW_W-1:0]    out_row_reg, out_row_next;
    logic [OUT_COL_W-1:0]    out_col_reg, out_col_next;
    logic                    last_reg, last_next;

    logic                    has_upper, is_final;
    logic [COL_W-1:0]        upper_start, upper_end;
    logic [COL_W+1:0]        col_x, col_m;
    logic                    col_ok;
    logic [1:0]              col_pop;

    // Results the current cell causes
    assign has_upper   = (in_row_reg != '0) && ((in_col_reg != '0) || (in_col_reg == last_col));
    assign is_final    = (in_row_reg == last_row) && (in_col_reg == last_col);
    assign upper_start = (in_col_reg != '0) ? in_col_reg - 1'b1 : in_col_reg;
    assign upper_end   = (in_col_reg == last_col) ? in_col_reg : in_col_reg - 1'b1;

    // Window column for this step: target column - 1 + step, zero outside the grid
    assign col_x   = (COL_W+2)'(tgt_col_reg) + (COL_W+2)'(step_reg);
    assign col_m   = col_x - 1'b1;
    assign col_ok  = (col_x != '0) && (col_m <= (COL_W+2)'(last_col));
    assign rd_col  = col_m[COL_W-1:0];
    // Flush rows have no row below, so the window is one up and current only
    assign col_pop = flush_reg ? 2'(rd_bits[1]) + 2'(rd_bits[0])
                               : 2'(rd_bits[2]) + 2'(rd_bits[1]) + 2'(rd_bits[0]);

    // Next state and outputs
    always_comb begin
        state_next   = state_reg;
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        tgt_col_next = tgt_col_reg;
        flush_next   = flush_reg;
        step_next    = step_reg;
        acc_next     = acc_reg;
        count_next   = count_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        last_next    = last_reg;
        line_ctrl    = '0;
        line_ctrl.wr_bit = bomb;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    line_ctrl.wr_en = 1'b1;
                    step_next       = '0;
                    if (has_upper) begin
                        state_next   = ST_SUM;
                        tgt_col_next = upper_start;
                        flush_next   = 1'b0;
                    end else if (is_final) begin
                        state_next   = ST_SUM;
                        tgt_col_next = '0;
                        flush_next   = 1'b1;
                    end else begin
                        state_next   = ST_UPDATE;
                    end
                end
            end
            ST_SUM: begin
                acc_next  = ((step_reg == '0) ? '0 : acc_reg)
                            + (col_ok ? COUNT_W'(col_pop) : '0);
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST) begin
                    state_next   = ST_OUTPUT;
                    count_next   = acc_next;
                    out_row_next = flush_reg ? OUT_ROW_W'(in_row_reg)
                                             : OUT_ROW_W'(in_row_reg - 1'b1);
                    out_col_next = OUT_COL_W'(tgt_col_reg);
                    last_next    = flush_reg ? (tgt_col_reg == last_col)
                                             : ((tgt_col_reg == upper_end) && !is_final);
                end
            end
            ST_OUTPUT: begin
                if (m_tready) begin
                    step_next = '0;
                    priority if (!flush_reg && tgt_col_reg != upper_end) begin
                        state_next   = ST_SUM;
                        tgt_col_next = tgt_col_reg + 1'b1;
                    end else if (!flush_reg && is_final) begin
                        state_next   = ST_SUM;
                        tgt_col_next = '0;
                        flush_next   = 1'b1;
                    end else if (flush_reg && tgt_col_reg != last_col) begin
                        state_next   = ST_SUM;
                        tgt_col_next = tgt_col_reg + 1'b1;
                    end else begin
                        state_next   = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                state_next = ST_IDLE;
                if (in_col_reg == last_col) begin
                    in_col_next = '0;
                    if (in_row_reg == last_row) begin
                        in_row_next     = '0;
                        line_ctrl.clear = 1'b1;
                    end else begin
                        in_row_next       = in_row_reg + 1'b1;
                        line_ctrl.advance = 1'b1;
                    end
                end else begin
                    in_col_next = in_col_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Grid size change starts a new frame
        if (restart) begin
            state_next      = ST_IDLE;
            in_row_next     = '0;
            in_col_next     = '0;
            line_ctrl.clear = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            tgt_col_reg <= '0;
            flush_reg   <= 1'b0;
            step_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            tgt_col_reg <= tgt_col_next;
            flush_reg   <= flush_next;
            step_reg    <= step_next;
        end
    end

    // Accumulator and result payload
    always_ff @(posedge aclk) begin
        acc_reg     <= acc_next;
        count_reg   <= count_next;
        out_row_reg <= out_row_next;
        out_col_reg <= out_col_next;
        last_reg    <= last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUTPUT);
    assign wr_col   = in_col_reg;
    assign count    = count_reg;
    assign out_row  = out_row_reg;
    assign out_col  = out_col_reg;
    assign run_last = last_reg;

`ifndef SYNTHESIS
    // Input and result sides never open together
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // A 3x3 window never holds more than nine bits
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (count <= COUNT_W'(9)))
        else $error("window count above nine");

    // Column walk stays inside the grid
    a_tgt_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM || state_reg == ST_OUTPUT) |-> (tgt_col_reg <= last_col))
        else $error("target column beyond the last column");

    // Position update returns to idle on the next cycle
    a_update_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE) |=> (state_reg == ST_IDLE))
        else $error("update did not return to idle");

    // Flush results belong to the last row
    a_flush_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && flush_reg) |-> (in_row_reg == last_row))
        else $error("flush outside the last row");
`endif

endmodule

`default_nettype wire

@@ sv/binary_grid_neighbour_count.sv @@
// Streaming 3x3 neighbour count over a binary grid, top level.
// Holds the grid size registers and joins the sequencer and line stores.
// Depends on bgnc_pkg, bgnc_lines and bgnc_seq.
//
// Usage:
//   Cells arrive one bit per beat in raster order on the s_ channel. Each
//   cell's 3x3 window count (self included, outside cells zero) leaves on the
//   m_ channel in raster order once the window is complete; the final cell
//   of a frame flushes the whole last row. m_tlast marks the last result a
//   given input beat causes.
//   Sequence: an input beat that causes no result is accepted, then the
//   position is updated. Each result is summed column by column on the
//   shared window adder and then held in the output register until taken;
//   the position update follows the last result.
//   s_tready is high only while the sequencer is idle.
//   A stalled receiver holds the result in the output register and the
//   sequencer waits; nothing is lost.
//   Reset (aresetn low, synchronous) clears the line stores and position and sets
//   the grid to 3 x 3. A write on the cfg_ channel sets a grid dimension and restarts
//   the frame; the user makes it only while the block is idle; the block does not enforce this.
`default_nettype none

module binary_grid_neighbour_count #(
    parameter int   MAX_COLS = bgnc_pkg::MAX_COLS_DEF,
    localparam int  COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bgnc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bgnc_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input cells
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,   // [0] bomb, [7:1] zero
    // results
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [23:0]                             m_tdata,   // [3:0] count, [13:4] out_row,
                                                               // [18:14] out_col, [23:19] zero
    output logic                                    m_tlast    // run_last
);
    import bgnc_pkg::*;

    logic [CFG_ROWS_W-1:0] grid_rows_reg, grid_rows_next;
    logic [CFG_COLS_W-1:0] grid_cols_reg, grid_cols_next;
    logic                  restart;
    logic [CFG_ROWS_W-1:0] last_row;
    logic [COL_W-1:0]      last_col;

    line_ctrl_t            line_ctrl;
    logic [COL_W-1:0]      wr_col;
    logic [COL_W-1:0]      rd_col;
    logic [2:0]            rd_bits;
    logic [COUNT_W-1:0]    count;
    logic [OUT_ROW_W-1:0]  out_row;
    logic [OUT_COL_W-1:0]  out_col;
    logic                  run_last;

    // Configuration beats; unknown indexes are ignored
    assign cfg_ready = 1'b1;

    always_comb begin
        grid_rows_next = grid_rows_reg;
        grid_cols_next = grid_cols_reg;
        restart        = 1'b0;
        if (cfg_valid) begin
            if (cfg_index == CFG_IDX_ROWS) begin
                grid_rows_next = cfg_data[CFG_ROWS_W-1:0];
                restart        = 1'b1;
            end else if (cfg_index == CFG_IDX_COLS) begin
                grid_cols_next = cfg_data[CFG_COLS_W-1:0];
                restart        = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= GRID_ROWS_RST;
            grid_cols_reg <= GRID_COLS_RST;
        end else begin
            grid_rows_reg <= grid_rows_next;
            grid_cols_reg <= grid_cols_next;
        end
    end

    // Last row and column indexes, dimensions clamped to 1..max
    always_comb begin
        if (grid_rows_reg == '0) begin
            last_row = '0;
        end else if (int'(grid_rows_reg) > MAX_ROWS) begin
            last_row = CFG_ROWS_W'(MAX_ROWS - 1);
        end else begin
            last_row = grid_rows_reg - 1'b1;
        end
        if (grid_cols_reg == '0) begin
            last_col = '0;
        end else if (int'(grid_cols_reg) > MAX_COLS) begin
            last_col = COL_W'(MAX_COLS - 1);
        end else begin
            last_col = COL_W'(grid_cols_reg - 1'b1);
        end
    end

    bgnc_seq #(
        .MAX_COLS (MAX_COLS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .restart   (restart),
        .last_row  (last_row),
        .last_col  (last_col),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .bomb      (s_tdata[0]),
        .line_ctrl (line_ctrl),
        .wr_col    (wr_col),
        .rd_col    (rd_col),
        .rd_bits   (rd_bits),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .count     (count),
        .out_row   (out_row),
        .out_col   (out_col),
        .run_last  (run_last)
    );

    bgnc_lines #(
        .MAX_COLS (MAX_COLS)
    ) u_lines (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (line_ctrl),
        .wr_col  (wr_col),
        .rd_col  (rd_col),
        .rd_bits (rd_bits)
    );

    // Result beat packing
    assign m_tdata = {5'd0, out_col, out_row, count};
    assign m_tlast = run_last;

endmodule

`default_nettype wire
